>>> rtl/lmcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcf_pkg
// Shared types and constants for the LED matrix chain framebuffer.
// ----------------------------------------------------------------------------
package lmcf_pkg;

   localparam int MAX_DEVICES   = 16;
   localparam int ROWS_PER_DEV  = 8;
   localparam int DEV_W         = $clog2(MAX_DEVICES);
   localparam int ROW_W         = $clog2(ROWS_PER_DEV);
   localparam int SHADOW_DEPTH  = MAX_DEVICES * ROWS_PER_DEV;
   localparam int IDX_W         = $clog2(SHADOW_DEPTH);
   localparam int COUNT_W       = 5;
   localparam int ROW_DATA_W    = 8;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_DEVICES);

   // actions
   localparam logic [2:0] ACT_WRITE_POINT   = 3'd0;
   localparam logic [2:0] ACT_READ_POINT    = 3'd1;
   localparam logic [2:0] ACT_WRITE_ROW     = 3'd2;
   localparam logic [2:0] ACT_WRITE_LED     = 3'd3;
   localparam logic [2:0] ACT_WRITE_CONTROL = 3'd4;
   localparam logic [2:0] ACT_CLEAR_ALL     = 3'd5;
   localparam logic [2:0] ACT_REFRESH_ROW   = 3'd6;

   // device register opcodes
   localparam logic [3:0] OP_NOOP       = 4'd0;
   localparam logic [3:0] OP_BRIGHTNESS = 4'd10;
   localparam logic [3:0] OP_SCAN_LIMIT = 4'd11;

   localparam logic [7:0] INTENSITY_MAX  = 8'd15;
   localparam logic [7:0] SCAN_LIMIT_MAX = 8'd7;

   localparam logic [7:0] LED_MASK_MSB = 8'b1000_0000;
   localparam logic [7:0] PIX_MASK_LSB = 8'b0000_0001;

   localparam logic RESULT_WORD   = 1'b0;
   localparam logic RESULT_ANSWER = 1'b1;

   typedef struct packed {
      logic [2:0] action;
      logic [4:0] x_coord;
      logic [4:0] y_coord;
      logic       bit_value;
      logic [3:0] device;
      logic [2:0] row_index;
      logic [2:0] column_index;
      logic [7:0] data_byte;
      logic [3:0] opcode;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0]      pix_idx;
      logic [ROW_DATA_W-1:0] pix_mask;
      logic [IDX_W-1:0]      row_idx;
      logic [ROW_DATA_W-1:0] led_mask;
      logic [3:0]            row_op;
      logic [DEV_W-1:0]      last_pos;
      logic [DEV_W-1:0]      target;
      logic                  dev_active;
      logic                  ctl_ok;
   } dec_type;

   typedef struct packed {
      logic                  rd_en;
      logic [IDX_W-1:0]      raddr;
      logic                  wr_en;
      logic [IDX_W-1:0]      waddr;
      logic [ROW_DATA_W-1:0] wdata;
      logic                  clear;
   } shd_req_type;

endpackage

>>> rtl/lmcf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/lmcf_shadow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcf_shadow
// Shadow row store: RAM plus per-entry valid bits; unwritten rows read zero.
// ----------------------------------------------------------------------------
module lmcf_shadow (
   input  logic                           clock,
   input  logic                           reset,
   input  lmcf_pkg::shd_req_type          req,
   output logic [lmcf_pkg::ROW_DATA_W-1:0] rdata
);

   logic [lmcf_pkg::SHADOW_DEPTH-1:0] valid_ff;
   logic [lmcf_pkg::SHADOW_DEPTH-1:0] valid_in;
   logic                              rvalid_ff;
   logic [lmcf_pkg::ROW_DATA_W-1:0]   ram_rdata;

   lmcf_ram #(
      .WIDTH (lmcf_pkg::ROW_DATA_W),
      .DEPTH (lmcf_pkg::SHADOW_DEPTH)
   ) u_ram (
      .clock (clock),
      .wr_en (req.wr_en),
      .waddr (req.waddr),
      .wdata (req.wdata),
      .rd_en (req.rd_en),
      .raddr (req.raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // valid flag travels with the read data
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rvalid_ff <= valid_ff[req.raddr];
      end
   end

   assign rdata = rvalid_ff ? ram_rdata : '0;

endmodule

>>> rtl/lmcf_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcf_decode
// Pixel mapping, active chain length and range checks for the held item.
// ----------------------------------------------------------------------------
module lmcf_decode (
   input  lmcf_pkg::item_type             item,
   input  logic [lmcf_pkg::COUNT_W-1:0]   device_count,
   output lmcf_pkg::dec_type              dec
);

   logic [4:0] xm;
   logic [4:0] ym;
   logic       count_bad;

   always_comb begin
      xm = ~item.x_coord;
      ym = ~item.y_coord;
      // zero or oversized count means the full chain
      count_bad = (device_count == '0) ||
                  (device_count > lmcf_pkg::COUNT_W'(lmcf_pkg::MAX_DEVICES));

      dec.pix_idx    = {ym[4:3], xm[4:3], ~ym[2:0]};
      dec.pix_mask   = lmcf_pkg::PIX_MASK_LSB << xm[2:0];
      dec.row_idx    = {item.device, item.row_index};
      dec.led_mask   = lmcf_pkg::LED_MASK_MSB >> item.column_index;
      dec.row_op     = {1'b0, item.row_index} + 4'd1;
      dec.last_pos   = count_bad ? lmcf_pkg::DEV_W'(lmcf_pkg::MAX_DEVICES - 1)
                                 : lmcf_pkg::DEV_W'(device_count - 5'd1);
      dec.target     = dec.last_pos - item.device;
      dec.dev_active = (item.device <= dec.last_pos);
      dec.ctl_ok     = !((item.opcode == lmcf_pkg::OP_BRIGHTNESS) &&
                         (item.data_byte > lmcf_pkg::INTENSITY_MAX)) &&
                       !((item.opcode == lmcf_pkg::OP_SCAN_LIMIT) &&
                         (item.data_byte > lmcf_pkg::SCAN_LIMIT_MAX));
   end

endmodule

>>> rtl/led_matrix_chain_framebuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_chain_framebuffer
// Shadow framebuffer for a chain of 8x8 LED drivers, emitting chain words.
// ----------------------------------------------------------------------------
// Flow: LOOKUP decodes the accepted item and starts any shadow read; UPDATE
//   modifies a point or LED row or loads a read answer; FRAME and SWEEP then
//   stream chain words one per cycle while the output is not stalled.
//   A new item is accepted only in IDLE, after the current one is done.
// Reset: synchronous; valid bits clear the whole shadow at once (no sweep),
//   device count returns to 16, the output register empties.
module led_matrix_chain_framebuffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [4:0]  req_x_coord,
   input  logic [4:0]  req_y_coord,
   input  logic        req_bit_value,
   input  logic [3:0]  req_device,
   input  logic [2:0]  req_row_index,
   input  logic [2:0]  req_column_index,
   input  logic [7:0]  req_data_byte,
   input  logic [3:0]  req_opcode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_spi_opcode,
   output logic [7:0]  rsp_spi_data,
   output logic        rsp_point_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_device_count
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_FRAME  = 5'b01000,
      ST_SWEEP  = 5'b10000
   } state_type;

   state_type                            state_ff, state_in;
   lmcf_pkg::item_type                   item_ff, item_in;
   logic [lmcf_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [lmcf_pkg::DEV_W-1:0]           cnt_ff, cnt_in;
   logic [lmcf_pkg::DEV_W-1:0]           cnt_next;
   logic [lmcf_pkg::DEV_W-1:0]           tgt_ff, tgt_in;
   logic [3:0]                           frm_op_ff, frm_op_in;
   logic [7:0]                           frm_data_ff, frm_data_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 kind_ff, kind_in;
   logic [3:0]                           op_ff, op_in;
   logic [7:0]                           data_ff, data_in;
   logic                                 pv_ff, pv_in;
   logic                                 last_ff, last_in;
   logic                                 slot_free;
   logic                                 word_last;
   logic [7:0]                           new_row;
   lmcf_pkg::dec_type                    dec;
   lmcf_pkg::shd_req_type                shd;
   logic [lmcf_pkg::ROW_DATA_W-1:0]      shd_rdata;

   lmcf_decode u_decode (
      .item         (item_ff),
      .device_count (count_ff),
      .dec          (dec)
   );

   lmcf_shadow u_shadow (
      .clock (clock),
      .reset (reset),
      .req   (shd),
      .rdata (shd_rdata)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign word_last = (cnt_ff == dec.last_pos);
   assign cnt_next  = cnt_ff + 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      count_in    = count_ff;
      cnt_in      = cnt_ff;
      tgt_in      = tgt_ff;
      frm_op_in   = frm_op_ff;
      frm_data_in = frm_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in     = kind_ff;
      op_in       = op_ff;
      data_in     = data_ff;
      pv_in       = pv_ff;
      last_in     = last_ff;
      new_row     = '0;
      shd         = '0;
      shd.raddr   = dec.pix_idx;
      shd.waddr   = dec.pix_idx;

      if (csr_valid) begin
         count_in = csr_device_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in.action       = req_action;
               item_in.x_coord      = req_x_coord;
               item_in.y_coord      = req_y_coord;
               item_in.bit_value    = req_bit_value;
               item_in.device       = req_device;
               item_in.row_index    = req_row_index;
               item_in.column_index = req_column_index;
               item_in.data_byte    = req_data_byte;
               item_in.opcode       = req_opcode;
               state_in             = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            cnt_in = '0;
            tgt_in = dec.target;
            unique case (item_ff.action)
               lmcf_pkg::ACT_WRITE_POINT, lmcf_pkg::ACT_READ_POINT: begin
                  shd.rd_en = 1'b1;
                  state_in  = ST_UPDATE;
               end
               lmcf_pkg::ACT_WRITE_LED: begin
                  shd.rd_en = dec.dev_active;
                  shd.raddr = dec.row_idx;
                  state_in  = dec.dev_active ? ST_UPDATE : ST_IDLE;
               end
               lmcf_pkg::ACT_WRITE_ROW: begin
                  shd.wr_en   = dec.dev_active;
                  shd.waddr   = dec.row_idx;
                  shd.wdata   = item_ff.data_byte;
                  frm_op_in   = dec.row_op;
                  frm_data_in = item_ff.data_byte;
                  state_in    = dec.dev_active ? ST_FRAME : ST_IDLE;
               end
               lmcf_pkg::ACT_WRITE_CONTROL: begin
                  frm_op_in   = item_ff.opcode;
                  frm_data_in = item_ff.data_byte;
                  state_in    = (dec.dev_active && dec.ctl_ok) ? ST_FRAME : ST_IDLE;
               end
               lmcf_pkg::ACT_CLEAR_ALL: begin
                  shd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
               lmcf_pkg::ACT_REFRESH_ROW: begin
                  // first word carries the far end of the chain
                  shd.rd_en = 1'b1;
                  shd.raddr = {dec.last_pos, item_ff.row_index};
                  state_in  = ST_SWEEP;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_UPDATE: begin
            unique case (item_ff.action)
               lmcf_pkg::ACT_WRITE_POINT: begin
                  shd.wr_en = 1'b1;
                  shd.wdata = item_ff.bit_value ? (shd_rdata | dec.pix_mask)
                                                : (shd_rdata & ~dec.pix_mask);
                  state_in  = ST_IDLE;
               end
               lmcf_pkg::ACT_READ_POINT: begin
                  // read data holds until the answer can be loaded
                  if (slot_free) begin
                     rsp_valid_in = 1'b1;
                     kind_in      = lmcf_pkg::RESULT_ANSWER;
                     op_in        = lmcf_pkg::OP_NOOP;
                     data_in      = '0;
                     pv_in        = |(shd_rdata & dec.pix_mask);
                     last_in      = 1'b0;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  new_row     = item_ff.bit_value ? (shd_rdata | dec.led_mask)
                                                  : (shd_rdata & ~dec.led_mask);
                  shd.wr_en   = 1'b1;
                  shd.waddr   = dec.row_idx;
                  shd.wdata   = new_row;
                  frm_op_in   = dec.row_op;
                  frm_data_in = new_row;
                  state_in    = ST_FRAME;
               end
            endcase
         end

         ST_FRAME: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = lmcf_pkg::RESULT_WORD;
               op_in        = (cnt_ff == tgt_ff) ? frm_op_ff : lmcf_pkg::OP_NOOP;
               data_in      = (cnt_ff == tgt_ff) ? frm_data_ff : 8'd0;
               pv_in        = 1'b0;
               last_in      = word_last;
               cnt_in       = cnt_next;
               if (word_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SWEEP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = lmcf_pkg::RESULT_WORD;
               op_in        = dec.row_op;
               data_in      = shd_rdata;
               pv_in        = 1'b0;
               last_in      = word_last;
               cnt_in       = cnt_next;
               if (word_last) begin
                  state_in = ST_IDLE;
               end else begin
                  shd.rd_en = 1'b1;
                  shd.raddr = {dec.last_pos - cnt_next, item_ff.row_index};
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= lmcf_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      cnt_ff      <= cnt_in;
      tgt_ff      <= tgt_in;
      frm_op_ff   <= frm_op_in;
      frm_data_ff <= frm_data_in;
      kind_ff     <= kind_in;
      op_ff       <= op_in;
      data_ff     <= data_in;
      pv_ff       <= pv_in;
      last_ff     <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_spi_opcode  = op_ff;
   assign rsp_spi_data    = data_ff;
   assign rsp_point_value = pv_ff;
   assign rsp_last        = last_ff;

endmodule

>>> rtl/lmcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmcf_checker
// Port-level checks for the LED matrix chain framebuffer.
// ----------------------------------------------------------------------------
module lmcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic [3:0] rsp_spi_opcode,
   input logic [7:0] rsp_spi_data,
   input logic       rsp_point_value,
   input logic       rsp_last
);

   // output register empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_result_kind,
         rsp_spi_opcode, rsp_spi_data, rsp_point_value, rsp_last}))
      else $error("stalled result changed");

   // one item in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second item while busy");

   a_answer_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |->
         rsp_spi_opcode == lmcf_pkg::OP_NOOP && rsp_spi_data == 8'd0 && !rsp_last)
      else $error("read answer carries word fields");

   a_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> !rsp_point_value)
      else $error("chain word carries a point value");

endmodule

bind led_matrix_chain_framebuffer lmcf_checker u_lmcf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_spi_opcode  (rsp_spi_opcode),
   .rsp_spi_data    (rsp_spi_data),
   .rsp_point_value (rsp_point_value),
   .rsp_last        (rsp_last)
);

>>> tb/sv/tb_led_matrix_chain_framebuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_chain_framebuffer
// Self-checking bench for the chain framebuffer. A scoreboard class keeps its
// own shadow rows and device count, predicts every chain word and pixel read
// answer for each accepted item, and checks the response channel in order.
// Directed corner items run first, then random phases over several device
// counts with random idling on both channels.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic       kind;
   logic [3:0] op;
   logic [7:0] data;
   logic       pixel;
   logic       is_last;
} chain_result_type;

class frame_scoreboard;
   logic [7:0]       shadow [128];
   logic [4:0]       count_reg;
   chain_result_type expected_q [$];
   int               errors;

   function new();
      foreach (shadow[i]) shadow[i] = '0;
      count_reg = lmcf_pkg::COUNT_RESET;
      errors    = 0;
   endfunction

   function void set_count(input logic [4:0] value);
      count_reg = value;
   endfunction

   // 0 and anything above the chain length fall back to the full chain
   function int unsigned active_devices();
      if (count_reg == 0 || count_reg > lmcf_pkg::MAX_DEVICES)
         return lmcf_pkg::MAX_DEVICES;
      return count_reg;
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction

   function void push_word(input logic [3:0] op, input logic [7:0] data,
                           input logic is_last);
      chain_result_type r;
      r.kind    = lmcf_pkg::RESULT_WORD;
      r.op      = op;
      r.data    = data;
      r.pixel   = 1'b0;
      r.is_last = is_last;
      expected_q.push_back(r);
   endfunction

   // addressed device sits at position n-1-dev in send order
   function void push_frame(input logic [3:0] dev, input logic [3:0] op,
                            input logic [7:0] data);
      int unsigned n;
      int unsigned target;
      n      = active_devices();
      target = n - 1 - dev;
      for (int unsigned i = 0; i < n; i++) begin
         if (i == target)
            push_word(op, data, i == n - 1);
         else
            push_word(lmcf_pkg::OP_NOOP, 8'h00, i == n - 1);
      end
   endfunction

   // an item that changes nothing and sends nothing
   function bit ignored(input lmcf_pkg::item_type it);
      case (it.action)
         lmcf_pkg::ACT_WRITE_ROW, lmcf_pkg::ACT_WRITE_LED, lmcf_pkg::ACT_WRITE_CONTROL:
            return it.device >= active_devices();
         lmcf_pkg::ACT_WRITE_POINT, lmcf_pkg::ACT_READ_POINT, lmcf_pkg::ACT_CLEAR_ALL,
         lmcf_pkg::ACT_REFRESH_ROW:
            return 1'b0;
         default:
            return 1'b1;
      endcase
   endfunction

   function void note_item(input lmcf_pkg::item_type it);
      logic [4:0]       xm;
      logic [4:0]       ym;
      logic [6:0]       pix_idx;
      logic [6:0]       row_idx;
      logic [2:0]       pix_bit;
      logic [7:0]       mask;
      int unsigned      n;
      chain_result_type r;
      n       = active_devices();
      // mirrored mapping: xm = 31-x, ym = 31-y
      xm      = ~it.x_coord;
      ym      = ~it.y_coord;
      pix_idx = {ym[4:3], xm[4:3], 3'd7 - ym[2:0]};
      pix_bit = xm[2:0];
      row_idx = {it.device, it.row_index};
      case (it.action)
         lmcf_pkg::ACT_WRITE_POINT: begin
            shadow[pix_idx][pix_bit] = it.bit_value;
         end
         lmcf_pkg::ACT_READ_POINT: begin
            r.kind    = lmcf_pkg::RESULT_ANSWER;
            r.op      = '0;
            r.data    = '0;
            r.pixel   = shadow[pix_idx][pix_bit];
            r.is_last = 1'b0;
            expected_q.push_back(r);
         end
         lmcf_pkg::ACT_WRITE_ROW: begin
            if (it.device < n) begin
               shadow[row_idx] = it.data_byte;
               push_frame(it.device, 4'(it.row_index) + 4'd1, it.data_byte);
            end
         end
         lmcf_pkg::ACT_WRITE_LED: begin
            if (it.device < n) begin
               mask = lmcf_pkg::LED_MASK_MSB >> it.column_index;
               if (it.bit_value)
                  shadow[row_idx] = shadow[row_idx] | mask;
               else
                  shadow[row_idx] = shadow[row_idx] & ~mask;
               push_frame(it.device, 4'(it.row_index) + 4'd1, shadow[row_idx]);
            end
         end
         lmcf_pkg::ACT_WRITE_CONTROL: begin
            if (it.device < n &&
                !(it.opcode == lmcf_pkg::OP_BRIGHTNESS &&
                  it.data_byte > lmcf_pkg::INTENSITY_MAX) &&
                !(it.opcode == lmcf_pkg::OP_SCAN_LIMIT &&
                  it.data_byte > lmcf_pkg::SCAN_LIMIT_MAX))
               push_frame(it.device, it.opcode, it.data_byte);
         end
         lmcf_pkg::ACT_CLEAR_ALL: begin
            foreach (shadow[i]) shadow[i] = '0;
         end
         lmcf_pkg::ACT_REFRESH_ROW: begin
            for (int unsigned i = 0; i < n; i++)
               push_word(4'(it.row_index) + 4'd1,
                         shadow[{4'(n - 1 - i), it.row_index}], i == n - 1);
         end
         default: ;
      endcase
   endfunction

   function void report(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   function void check_result(input chain_result_type got);
      chain_result_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %p", $time, got);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      report("result_kind", 8'(want.kind), 8'(got.kind));
      report("spi_opcode", 8'(want.op), 8'(got.op));
      report("spi_data", want.data, got.data);
      report("point_value", 8'(want.pixel), 8'(got.pixel));
      report("last", 8'(want.is_last), 8'(got.is_last));
   endfunction
endclass

module tb_led_matrix_chain_framebuffer;

   localparam logic [2:0] ACT_UNUSED   = 3'd7;
   localparam int         CYCLE_LIMIT  = 300000;
   localparam int         SETTLE_WAIT  = 24;
   localparam int         PHASE_ITEMS  = 24;
   localparam int         PHASES       = 8;
   localparam int         ITEM_W       = $bits(lmcf_pkg::item_type);

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   lmcf_pkg::item_type req_item         = '0;
   logic               rsp_ready        = 1'b0;
   logic               csr_valid        = 1'b0;
   logic [4:0]         csr_device_count = '0;

   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_result_kind;
   logic [3:0] rsp_spi_opcode;
   logic [7:0] rsp_spi_data;
   logic       rsp_point_value;
   logic       rsp_last;
   logic       csr_ready;

   frame_scoreboard sb = new();
   bit              no_gaps = 1'b0;
   int unsigned     cycle_count = 0;
   logic [9:0]      touched_q [$];

   led_matrix_chain_framebuffer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_item.action),
      .req_x_coord      (req_item.x_coord),
      .req_y_coord      (req_item.y_coord),
      .req_bit_value    (req_item.bit_value),
      .req_device       (req_item.device),
      .req_row_index    (req_item.row_index),
      .req_column_index (req_item.column_index),
      .req_data_byte    (req_item.data_byte),
      .req_opcode       (req_item.opcode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_spi_opcode   (rsp_spi_opcode),
      .rsp_spi_data     (rsp_spi_data),
      .rsp_point_value  (rsp_point_value),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_device_count (csr_device_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_result_kind, rsp_spi_opcode, rsp_spi_data,
                          rsp_point_value, rsp_last});
      rsp_ready <= no_gaps || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_led_matrix_chain_framebuffer: FAIL");
         $finish;
      end
   end

   function automatic lmcf_pkg::item_type make_item(input logic [2:0] action,
                                                    input logic [4:0] x,
                                                    input logic [4:0] y, input logic value,
                                                    input logic [3:0] dev,
                                                    input logic [2:0] row,
                                                    input logic [2:0] col,
                                                    input logic [7:0] data,
                                                    input logic [3:0] op);
      lmcf_pkg::item_type it;
      it.action       = action;
      it.x_coord      = x;
      it.y_coord      = y;
      it.bit_value    = value;
      it.device       = dev;
      it.row_index    = row;
      it.column_index = col;
      it.data_byte    = data;
      it.opcode       = op;
      return it;
   endfunction

   function automatic lmcf_pkg::item_type random_item();
      lmcf_pkg::item_type it;
      int unsigned        pick;
      int unsigned        n;
      logic [9:0]         xy;
      it   = lmcf_pkg::item_type'(ITEM_W'({$urandom, $urandom}));
      n    = sb.active_devices();
      pick = $urandom_range(99);
      // mostly live devices so frames actually go out
      if ($urandom_range(9) < 8)
         it.device = 4'($urandom_range(n - 1));
      if (pick < 20) begin
         it.action = lmcf_pkg::ACT_WRITE_POINT;
         touched_q.push_back({it.x_coord, it.y_coord});
         if (touched_q.size() > 16)
            void'(touched_q.pop_front());
      end else if (pick < 40) begin
         it.action = lmcf_pkg::ACT_READ_POINT;
         if (touched_q.size() > 0 && $urandom_range(9) < 6) begin
            xy = touched_q[$urandom_range(touched_q.size() - 1)];
            {it.x_coord, it.y_coord} = xy;
         end
      end else if (pick < 55) begin
         it.action = lmcf_pkg::ACT_WRITE_ROW;
      end else if (pick < 70) begin
         it.action = lmcf_pkg::ACT_WRITE_LED;
      end else if (pick < 82) begin
         it.action = lmcf_pkg::ACT_WRITE_CONTROL;
         case ($urandom_range(3))
            0: begin
               it.opcode    = lmcf_pkg::OP_BRIGHTNESS;
               it.data_byte = 8'($urandom_range(31));
            end
            1: begin
               it.opcode    = lmcf_pkg::OP_SCAN_LIMIT;
               it.data_byte = 8'($urandom_range(15));
            end
            default: ;
         endcase
      end else if (pick < 95) begin
         it.action = lmcf_pkg::ACT_REFRESH_ROW;
      end else if (pick < 97) begin
         it.action = lmcf_pkg::ACT_CLEAR_ALL;
      end else begin
         it.action = ACT_UNUSED;
      end
      return it;
   endfunction

   task automatic send_item(input lmcf_pkg::item_type it);
      while (!no_gaps && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      sb.note_item(it);
   endtask

   // stop sending, let every expected result arrive, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_count(input logic [4:0] value);
      csr_valid        <= 1'b1;
      csr_device_count <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_count(value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [4:0]         count_values [PHASES];
      int unsigned        done;
      lmcf_pkg::item_type it;
      count_values = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd9, 5'd17, 5'd12};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_count(5'd16);

      // corners of the pixel map, read back and cleared
      send_item(make_item(lmcf_pkg::ACT_WRITE_POINT, 5'd0, 5'd0, 1'b1, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_WRITE_POINT, 5'd31, 5'd31, 1'b1, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_READ_POINT, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_READ_POINT, 5'd31, 5'd31, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_READ_POINT, 5'd1, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_WRITE_POINT, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_READ_POINT, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      // rows at both ends of the chain, LEDs at both ends of a row
      send_item(make_item(lmcf_pkg::ACT_WRITE_ROW, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'hff, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_WRITE_ROW, 5'd0, 5'd0, 1'b0, 4'd15, 3'd7, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_WRITE_LED, 5'd0, 5'd0, 1'b1, 4'd3, 3'd2, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_WRITE_LED, 5'd0, 5'd0, 1'b1, 4'd3, 3'd2, 3'd7,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_WRITE_LED, 5'd0, 5'd0, 1'b0, 4'd3, 3'd2, 3'd0,
                          8'h00, 4'd0));
      // intensity and scan limit at and past their range
      send_item(make_item(lmcf_pkg::ACT_WRITE_CONTROL, 5'd0, 5'd0, 1'b0, 4'd1, 3'd0, 3'd0,
                          lmcf_pkg::INTENSITY_MAX, lmcf_pkg::OP_BRIGHTNESS));
      send_item(make_item(lmcf_pkg::ACT_WRITE_CONTROL, 5'd0, 5'd0, 1'b0, 4'd1, 3'd0, 3'd0,
                          lmcf_pkg::INTENSITY_MAX + 8'd1, lmcf_pkg::OP_BRIGHTNESS));
      send_item(make_item(lmcf_pkg::ACT_WRITE_CONTROL, 5'd0, 5'd0, 1'b0, 4'd2, 3'd0, 3'd0,
                          lmcf_pkg::SCAN_LIMIT_MAX, lmcf_pkg::OP_SCAN_LIMIT));
      send_item(make_item(lmcf_pkg::ACT_WRITE_CONTROL, 5'd0, 5'd0, 1'b0, 4'd2, 3'd0, 3'd0,
                          lmcf_pkg::SCAN_LIMIT_MAX + 8'd1, lmcf_pkg::OP_SCAN_LIMIT));
      send_item(make_item(lmcf_pkg::ACT_WRITE_CONTROL, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'hab, lmcf_pkg::OP_NOOP));
      send_item(make_item(lmcf_pkg::ACT_WRITE_CONTROL, 5'd0, 5'd0, 1'b0, 4'd15, 3'd0, 3'd0,
                          8'hff, 4'd3));
      send_item(make_item(lmcf_pkg::ACT_WRITE_CONTROL, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd15));
      send_item(make_item(lmcf_pkg::ACT_REFRESH_ROW, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_REFRESH_ROW, 5'd0, 5'd0, 1'b0, 4'd0, 3'd7, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(ACT_UNUSED, 5'd31, 5'd31, 1'b1, 4'd15, 3'd7, 3'd7, 8'hff, 4'd15));
      send_item(make_item(lmcf_pkg::ACT_CLEAR_ALL, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));
      send_item(make_item(lmcf_pkg::ACT_REFRESH_ROW, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0, 3'd0,
                          8'h00, 4'd0));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_count(count_values[p]);
         no_gaps = (p == 3);
         if (p == 1) begin
            // single device: other chain positions are dead, points still land
            send_item(make_item(lmcf_pkg::ACT_WRITE_ROW, 5'd0, 5'd0, 1'b0, 4'd5, 3'd1, 3'd0,
                                8'h5a, 4'd0));
            send_item(make_item(lmcf_pkg::ACT_WRITE_LED, 5'd0, 5'd0, 1'b1, 4'd15, 3'd0,
                                3'd0, 8'h00, 4'd0));
            send_item(make_item(lmcf_pkg::ACT_WRITE_CONTROL, 5'd0, 5'd0, 1'b0, 4'd1, 3'd0,
                                3'd0, 8'h01, lmcf_pkg::OP_BRIGHTNESS));
            send_item(make_item(lmcf_pkg::ACT_WRITE_POINT, 5'd0, 5'd0, 1'b1, 4'd0, 3'd0,
                                3'd0, 8'h00, 4'd0));
            send_item(make_item(lmcf_pkg::ACT_READ_POINT, 5'd0, 5'd0, 1'b0, 4'd0, 3'd0,
                                3'd0, 8'h00, 4'd0));
         end
         done = 0;
         while (done < PHASE_ITEMS) begin
            it = random_item();
            if (!sb.ignored(it))
               done++;
            send_item(it);
            if (p == 2 && done == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               while (sb.pending() != 0) @(posedge clock);
            end
         end
      end
      no_gaps = 1'b0;
      drain();

      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_led_matrix_chain_framebuffer: PASS");
      else
         $display("tb_led_matrix_chain_framebuffer: FAIL");
      $finish;
   end

endmodule
